FILE: rtl/nffla_pkg.sv
// Shared constants, codes and types of the next-fit free-list allocator.
package nffla_pkg;

   localparam int ARENA_UNITS          = 65536;
   localparam int UNIT_W               = 16;
   localparam int SIZE_W               = 17;
   localparam int BYTES_W              = 32;
   localparam int HEADER_BYTES         = 8;
   localparam int HDR_SHIFT            = $clog2(HEADER_BYTES);
   localparam int NUNIT_W              = BYTES_W - HDR_SHIFT + 1;
   localparam int MAX_FREE_EXTENTS_DEF = 64;

   localparam logic [SIZE_W-1:0] MIN_GROWTH   = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0] GROWTH_RESET = SIZE_W'(1024 * 32);
   localparam logic [SIZE_W-1:0] BREAK_LIMIT  = SIZE_W'(ARENA_UNITS - 1);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OOM  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [1:0] {
      CTX_ALLOC,
      CTX_GROW,
      CTX_FREE
   } ctx_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_ACCEPT,
      DP_WALK_RD,
      DP_WALK_CHK,
      DP_ALLOC_END,
      DP_GROW,
      DP_FREE_CHK,
      DP_PLACE_START,
      DP_PRED_SCAN,
      DP_PLACE_CHK,
      DP_SHD_START,
      DP_SHD_MOVE,
      DP_SHU_START,
      DP_SHU_MOVE,
      DP_SHU_INS,
      DP_PLACE_END,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      ctx_type   ctx;
   } dp_cmd_type;

   typedef struct packed {
      logic free_bad0;
      logic fit;
      logic exact;
      logic at_rover;
      logic grow_fail;
      logic free_bad;
      logic count_gt1;
      logic scan_done;
      logic overlap;
      logic full;
      logic low;
      logic high;
      logic shd_more1;
      logic shd_more2;
      logic shu_start_more;
      logic shu_move_more;
      logic rsp_free;
   } dp_stat_type;

   typedef struct packed {
      logic [UNIT_W-1:0] start;
      logic [SIZE_W-1:0] size;
   } extent_type;

endpackage

FILE: rtl/nffla_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module nffla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/nffla_datapath.sv
// Allocator datapath: extent table, size store, pointers and result register.
module nffla_datapath import nffla_pkg::*; #(
   parameter int MAX_EXT = MAX_FREE_EXTENTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [SIZE_W-1:0]   csr_wr_data,
   input  logic [BYTES_W-1:0]  req_size_bytes,
   input  logic [UNIT_W-1:0]   req_payload_unit,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [UNIT_W-1:0]   rsp_granted_unit,
   output logic [1:0]          rsp_status
);

   localparam int IW  = $clog2(MAX_EXT);
   localparam int CW  = $clog2(MAX_EXT + 1);
   localparam int CW1 = CW + 1;
   localparam int SW1 = SIZE_W + 1;
   localparam int AW  = $clog2(ARENA_UNITS);

   logic [SIZE_W-1:0]  growth_ff, growth_in;
   logic [SIZE_W-1:0]  break_ff, break_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      rover_ff, rover_in;
   logic [NUNIT_W-1:0] n_ff, n_in;
   logic [UNIT_W-1:0]  h_ff, h_in;
   logic [SIZE_W-1:0]  s_ff, s_in;
   logic [IW-1:0]      prev_ff, prev_in;
   logic [IW-1:0]      p_ff, p_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      rd_idx_ff;
   extent_type         pred_ff, pred_in;
   extent_type         nxt_ff, nxt_in;
   logic [UNIT_W-1:0]  res_unit_ff, res_unit_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [UNIT_W-1:0]  rsp_unit_ff, rsp_unit_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               ext_wr_en;
   logic [IW-1:0]      ext_wr_addr;
   extent_type         ext_wr_data;
   logic [IW-1:0]      ext_rd_addr;
   logic [$bits(extent_type)-1:0] ext_rd_raw;
   logic               st_wr_en;
   logic [SIZE_W-1:0]  st_wr_data;
   logic [SIZE_W-1:0]  st_rd_data;
   logic [UNIT_W-1:0]  pay_h;

   extent_type         ent;
   logic [IW-1:0]      next_p;
   logic [IW-1:0]      p_plus1;
   logic               has_next;
   logic [SIZE_W-1:0]  nu;
   logic [SIZE_W-1:0]  new_size;
   logic [SIZE_W-1:0]  pend;
   logic [SW1-1:0]     end_sum;
   logic               scan_found;
   logic [NUNIT_W-1:0] n_calc;

   function automatic logic [IW-1:0] next_of(input logic [IW-1:0] i,
                                             input logic [CW-1:0] c);
      logic [CW1-1:0] i1;
      i1 = CW1'(i) + CW1'(1);
      return (i1 < CW1'(c)) ? IW'(i1) : '0;
   endfunction

   // entry 0 is the sentinel and is never written
   assign ent      = (rd_idx_ff == '0) ? '0 : extent_type'(ext_rd_raw);
   assign next_p   = next_of(p_ff, count_ff);
   assign p_plus1  = p_ff + IW'(1);
   assign has_next = (CW1'(p_ff) + CW1'(1)) < CW1'(count_ff);
   assign nu       = (growth_ff < MIN_GROWTH) ? MIN_GROWTH : growth_ff;
   assign new_size = ent.size - n_ff[SIZE_W-1:0];
   assign pend     = SIZE_W'(pred_ff.start) + pred_ff.size;
   assign end_sum  = SW1'(h_ff) + SW1'(s_ff);
   assign pay_h    = req_payload_unit - UNIT_W'(1);
   assign scan_found = ent.start < h_ff;
   assign n_calc   = NUNIT_W'(req_size_bytes >> HDR_SHIFT)
                   + NUNIT_W'(|req_size_bytes[HDR_SHIFT-1:0]) + NUNIT_W'(1);

   always_comb begin
      stat.free_bad0 = (req_payload_unit < UNIT_W'(2))
                     || (SIZE_W'(pay_h) >= break_ff);
      stat.fit       = NUNIT_W'(ent.size) >= n_ff;
      stat.exact     = NUNIT_W'(ent.size) == n_ff;
      stat.at_rover  = p_ff == rover_ff;
      stat.grow_fail = (SW1'(break_ff) + SW1'(nu)) > SW1'(BREAK_LIMIT);
      stat.free_bad  = (st_rd_data == '0)
                     || ((SW1'(h_ff) + SW1'(st_rd_data)) > SW1'(break_ff));
      stat.count_gt1 = count_ff > CW'(1);
      stat.scan_done = scan_found || (idx_ff == IW'(1));
      stat.overlap   = (pend > SIZE_W'(h_ff))
                     || (has_next && (end_sum > SW1'(nxt_ff.start)));
      stat.low       = (p_ff != '0) && (pend == SIZE_W'(h_ff));
      stat.high      = has_next && (SW1'(nxt_ff.start) == end_sum);
      stat.full      = !stat.low && !stat.high && (CW1'(count_ff) >= CW1'(MAX_EXT));
      stat.shd_more1 = (CW1'(idx_ff) + CW1'(1)) < CW1'(count_ff);
      stat.shd_more2 = (CW1'(idx_ff) + CW1'(2)) < CW1'(count_ff);
      stat.shu_start_more = CW1'(count_ff) > (CW1'(p_ff) + CW1'(1));
      stat.shu_move_more  = CW1'(idx_ff) > (CW1'(p_ff) + CW1'(2));
      stat.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   // table read address: the walk, scans and shifts each prefetch one entry ahead
   always_comb begin
      unique case (cmd.op)
         DP_WALK_CHK:    ext_rd_addr = next_p;
         DP_PLACE_START: ext_rd_addr = IW'(count_ff - CW'(1));
         DP_PRED_SCAN:   ext_rd_addr = idx_ff - IW'(1);
         DP_SHD_START:   ext_rd_addr = idx_ff + IW'(1);
         DP_SHD_MOVE:    ext_rd_addr = idx_ff + IW'(2);
         DP_SHU_START:   ext_rd_addr = IW'(count_ff - CW'(1));
         DP_SHU_MOVE:    ext_rd_addr = idx_ff - IW'(2);
         default:        ext_rd_addr = p_ff;
      endcase
   end

   always_comb begin
      growth_in     = csr_wr_en ? csr_wr_data : growth_ff;
      break_in      = break_ff;
      count_in      = count_ff;
      rover_in      = rover_ff;
      n_in          = n_ff;
      h_in          = h_ff;
      s_in          = s_ff;
      prev_in       = prev_ff;
      p_in          = p_ff;
      idx_in        = idx_ff;
      pred_in       = pred_ff;
      nxt_in        = nxt_ff;
      res_unit_in   = res_unit_ff;
      res_status_in = res_status_ff;
      ext_wr_en     = 1'b0;
      ext_wr_addr   = p_ff;
      ext_wr_data   = ent;
      st_wr_en      = 1'b0;
      st_wr_data    = s_ff;

      unique case (cmd.op)
         DP_NOP, DP_WALK_RD, DP_RESULT: begin
         end
         DP_ACCEPT: begin
            res_unit_in   = '0;
            res_status_in = ST_OK;
            n_in          = n_calc;
            prev_in       = rover_ff;
            p_in          = next_of(rover_ff, count_ff);
            h_in          = pay_h;
         end
         DP_WALK_CHK: begin
            if (stat.fit) begin
               if (stat.exact) begin
                  h_in   = ent.start;
                  idx_in = p_ff;
               end else begin
                  // cut the grant from the tail of the extent
                  h_in        = ent.start + new_size[UNIT_W-1:0];
                  ext_wr_en   = 1'b1;
                  ext_wr_data = '{start: ent.start, size: new_size};
               end
            end else if (!stat.at_rover) begin
               prev_in = p_ff;
               p_in    = next_p;
            end
         end
         DP_ALLOC_END: begin
            st_wr_en    = 1'b1;
            st_wr_data  = n_ff[SIZE_W-1:0];
            rover_in    = prev_ff;
            res_unit_in = h_ff + UNIT_W'(1);
         end
         DP_GROW: begin
            if (stat.grow_fail) begin
               res_status_in = ST_OOM;
            end else begin
               h_in = break_ff[UNIT_W-1:0];
               s_in = nu;
            end
         end
         DP_FREE_CHK: begin
            s_in = st_rd_data;
         end
         DP_PLACE_START: begin
            if (stat.count_gt1) begin
               idx_in = IW'(count_ff - CW'(1));
            end else begin
               p_in    = '0;
               pred_in = '0;
            end
         end
         DP_PRED_SCAN: begin
            if (scan_found) begin
               p_in    = idx_ff;
               pred_in = ent;
            end else begin
               nxt_in = ent;
               if (idx_ff == IW'(1)) begin
                  p_in    = '0;
                  pred_in = '0;
               end else begin
                  idx_in = idx_ff - IW'(1);
               end
            end
         end
         DP_PLACE_CHK: begin
            if (stat.overlap) begin
               res_status_in = (cmd.ctx == CTX_GROW) ? ST_OOM : ST_OK;
            end else if (stat.full) begin
               res_status_in = ST_FULL;
            end else if (stat.low && stat.high) begin
               ext_wr_en   = 1'b1;
               ext_wr_data = '{start: pred_ff.start,
                               size: pred_ff.size + s_ff + nxt_ff.size};
               idx_in      = p_plus1;
            end else if (stat.low) begin
               ext_wr_en   = 1'b1;
               ext_wr_data = '{start: pred_ff.start, size: pred_ff.size + s_ff};
            end else if (stat.high) begin
               ext_wr_en   = 1'b1;
               ext_wr_addr = p_plus1;
               ext_wr_data = '{start: h_ff, size: nxt_ff.size + s_ff};
            end
         end
         DP_SHD_START: begin
            if (!stat.shd_more1) begin
               count_in = count_ff - CW'(1);
            end
         end
         DP_SHD_MOVE: begin
            ext_wr_en   = 1'b1;
            ext_wr_addr = idx_ff;
            idx_in      = idx_ff + IW'(1);
            if (!stat.shd_more2) begin
               count_in = count_ff - CW'(1);
            end
         end
         DP_SHU_START: begin
            idx_in = IW'(count_ff);
         end
         DP_SHU_MOVE: begin
            ext_wr_en   = 1'b1;
            ext_wr_addr = idx_ff;
            idx_in      = idx_ff - IW'(1);
         end
         DP_SHU_INS: begin
            ext_wr_en   = 1'b1;
            ext_wr_addr = p_plus1;
            ext_wr_data = '{start: h_ff, size: s_ff};
            count_in    = count_ff + CW'(1);
         end
         DP_PLACE_END: begin
            rover_in = p_ff;
            if (cmd.ctx == CTX_GROW) begin
               st_wr_en   = 1'b1;
               st_wr_data = s_ff;
               break_in   = SIZE_W'(h_ff) + s_ff;
               prev_in    = p_ff;
               p_in       = next_p;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_unit_in   = rsp_unit_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.op == DP_RESULT) begin
         rsp_valid_in  = 1'b1;
         rsp_unit_in   = res_unit_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         growth_ff    <= GROWTH_RESET;
         break_ff     <= SIZE_W'(1);
         count_ff     <= CW'(1);
         rover_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         growth_ff    <= growth_in;
         break_ff     <= break_in;
         count_ff     <= count_in;
         rover_ff     <= rover_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      h_ff          <= h_in;
      s_ff          <= s_in;
      prev_ff       <= prev_in;
      p_ff          <= p_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= ext_rd_addr;
      pred_ff       <= pred_in;
      nxt_ff        <= nxt_in;
      res_unit_ff   <= res_unit_in;
      res_status_ff <= res_status_in;
      rsp_unit_ff   <= rsp_unit_in;
      rsp_status_ff <= rsp_status_in;
   end

   nffla_ram #(
      .WIDTH ($bits(extent_type)),
      .DEPTH (MAX_EXT)
   ) u_extent_ram (
      .clock   (clock),
      .wr_en   (ext_wr_en),
      .wr_addr (ext_wr_addr),
      .wr_data (ext_wr_data),
      .rd_addr (ext_rd_addr),
      .rd_data (ext_rd_raw)
   );

   nffla_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (ARENA_UNITS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (h_ff[AW-1:0]),
      .wr_data (st_wr_data),
      .rd_addr (pay_h[AW-1:0]),
      .rd_data (st_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_unit = rsp_unit_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(1)) && (CW1'(count_ff) <= CW1'(MAX_EXT)))
      else $error("extent count out of range");
   a_rover_live: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_ACCEPT) |-> (CW'(rover_ff) < count_ff))
      else $error("rover beyond extent table at accept");
   a_break_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (break_ff >= $past(break_ff)))
      else $error("break pointer moved backward");
   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_RESULT) |-> stat.rsp_free)
      else $error("result loaded over an untaken result");
`endif

endmodule

FILE: rtl/nffla_ctrl.sv
// Allocator controller: sequences walk, growth, predecessor scan and table shifts.
module nffla_ctrl import nffla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_opcode,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK_RD,
      S_WALK_CHK,
      S_ALLOC_END,
      S_GROW,
      S_FREE_CHK,
      S_PLACE_START,
      S_PRED_SCAN,
      S_PLACE_CHK,
      S_SHD_START,
      S_SHD_MOVE,
      S_SHU_START,
      S_SHU_MOVE,
      S_SHU_INS,
      S_PLACE_END,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   ctx_type   ctx_ff, ctx_in;
   state_type after_shd;

   assign req_stall = state_ff != S_IDLE;
   assign after_shd = (ctx_ff == CTX_ALLOC) ? S_ALLOC_END : S_PLACE_END;

   always_comb begin
      cmd.ctx = ctx_ff;
      unique case (state_ff)
         S_IDLE:        cmd.op = req_valid ? DP_ACCEPT : DP_NOP;
         S_WALK_RD:     cmd.op = DP_WALK_RD;
         S_WALK_CHK:    cmd.op = DP_WALK_CHK;
         S_ALLOC_END:   cmd.op = DP_ALLOC_END;
         S_GROW:        cmd.op = DP_GROW;
         S_FREE_CHK:    cmd.op = DP_FREE_CHK;
         S_PLACE_START: cmd.op = DP_PLACE_START;
         S_PRED_SCAN:   cmd.op = DP_PRED_SCAN;
         S_PLACE_CHK:   cmd.op = DP_PLACE_CHK;
         S_SHD_START:   cmd.op = DP_SHD_START;
         S_SHD_MOVE:    cmd.op = DP_SHD_MOVE;
         S_SHU_START:   cmd.op = DP_SHU_START;
         S_SHU_MOVE:    cmd.op = DP_SHU_MOVE;
         S_SHU_INS:     cmd.op = DP_SHU_INS;
         S_PLACE_END:   cmd.op = DP_PLACE_END;
         S_DONE:        cmd.op = stat.rsp_free ? DP_RESULT : DP_NOP;
         default:       cmd.op = DP_NOP;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ctx_in   = ctx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_ALLOC) begin
                  ctx_in   = CTX_ALLOC;
                  state_in = S_WALK_RD;
               end else begin
                  ctx_in   = CTX_FREE;
                  state_in = stat.free_bad0 ? S_DONE : S_FREE_CHK;
               end
            end
         end
         S_WALK_RD: state_in = S_WALK_CHK;
         S_WALK_CHK: begin
            if (stat.fit) begin
               state_in = stat.exact ? S_SHD_START : S_ALLOC_END;
            end else if (stat.at_rover) begin
               state_in = S_GROW;
            end
         end
         S_ALLOC_END: state_in = S_DONE;
         S_GROW: begin
            if (stat.grow_fail) begin
               state_in = S_DONE;
            end else begin
               ctx_in   = CTX_GROW;
               state_in = S_PLACE_START;
            end
         end
         S_FREE_CHK:    state_in = stat.free_bad ? S_DONE : S_PLACE_START;
         S_PLACE_START: state_in = stat.count_gt1 ? S_PRED_SCAN : S_PLACE_CHK;
         S_PRED_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_PLACE_CHK;
            end
         end
         S_PLACE_CHK: begin
            priority if (stat.overlap || stat.full) begin
               state_in = S_DONE;
            end else if (stat.low && stat.high) begin
               state_in = S_SHD_START;
            end else if (stat.low || stat.high) begin
               state_in = S_PLACE_END;
            end else begin
               state_in = S_SHU_START;
            end
         end
         S_SHD_START: state_in = stat.shd_more1 ? S_SHD_MOVE : after_shd;
         S_SHD_MOVE: begin
            if (!stat.shd_more2) begin
               state_in = after_shd;
            end
         end
         S_SHU_START: state_in = stat.shu_start_more ? S_SHU_MOVE : S_SHU_INS;
         S_SHU_MOVE: begin
            if (!stat.shu_move_more) begin
               state_in = S_SHU_INS;
            end
         end
         S_SHU_INS: state_in = S_PLACE_END;
         S_PLACE_END: begin
            if (ctx_ff == CTX_GROW) begin
               ctx_in   = CTX_ALLOC;
               state_in = S_WALK_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctx_ff   <= CTX_ALLOC;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
      end
   end

endmodule

FILE: rtl/next_fit_free_list_allocator.sv
// Next-fit free-list allocator over a 64K-unit arena. One request at a time: while a
// request is in work req_stall is high; the result goes to an output register, so the
// next request is taken while the last result still waits for its transfer. An
// allocate walks the address-ordered extent table from the entry after the rover at
// one extent per cycle; an exact fit closes the gap by shifting the entries above it
// down. When the walk comes back to the rover, the arena grows from the break pointer:
// a predecessor scan from the top of the table down to the insertion point, then a
// merge or an insert that shifts the entries above it up by one a cycle (a merge with
// both neighbours shifts the entries above down instead), then the walk starts over.
// A free reads the size store, then runs the same scan and merge or insert; a bad free
// answers without them. The pace is one table entry per cycle, set by the extent
// table's one read and one write per cycle. A stalled result holds the block in its
// last state until the result register frees up. No clearing pass.
module next_fit_free_list_allocator import nffla_pkg::*; #(
   parameter int MAX_FREE_EXTENTS = MAX_FREE_EXTENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // configuration: growth chunk in units
   input  logic               csr_wr_en,
   input  logic [SIZE_W-1:0]  csr_wr_data,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [BYTES_W-1:0] req_size_bytes,
   input  logic [UNIT_W-1:0]  req_payload_unit,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [UNIT_W-1:0]  rsp_granted_unit,
   output logic [1:0]         rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // controller: owns sequencing and the request-side stall
   nffla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: extent table, size store, break/rover/count and result register
   nffla_datapath #(
      .MAX_EXT (MAX_FREE_EXTENTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_size_bytes   (req_size_bytes),
      .req_payload_unit (req_payload_unit),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_granted_unit (rsp_granted_unit),
      .rsp_status       (rsp_status)
   );

endmodule
